FILE: rtl/esdf_pkg.sv
`default_nettype none

package esdf_pkg;

	localparam int unsigned LengthBytesDefault = 4;
	localparam int unsigned LenW               = 28;
	localparam int unsigned PosW               = 16;
	localparam int unsigned TagW               = 8;

	localparam logic [TagW-1:0] TagEsDescr       = 8'd3;
	localparam logic [TagW-1:0] TagDecConfig     = 8'd4;
	localparam logic [LenW-1:0] SkipEsDescr      = 28'd3;
	localparam logic [LenW-1:0] SkipDecConfig    = 28'd13;
	localparam logic [TagW-1:0] WantedTagReset   = 8'd5;
	localparam logic [6:0]      LenBitsMask      = 7'h7F;
	localparam logic [PosW-1:0] PosMax           = 16'hFFFF;

	localparam logic RegWantedTag    = 1'b0;
	localparam logic RegBufferLength = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TAG     = 3'd1,
		PH_LEN     = 3'd2,
		PH_SKIP    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

endpackage

`default_nettype wire

FILE: rtl/es_descriptor_finder_unit.sv
`default_nettype none

// Scans a buffer of MPEG-4 descriptor bytes, one byte per word, for the first descriptor
// whose tag equals wanted_tag, skipping into ES and decoder-config descriptors and over
// all others, and reports the payload length and the payload bytes of the match. Every
// input word gives exactly one output word. The unit takes one word per clock cycle unless
// the sink holds off: a word sits in an input register, the parser state is updated by a
// single pass of logic, and the result lands in an output register; s_axis_tready
// drops only when both registers hold words the sink has not taken.
// Set first_byte on the first byte of each buffer; write registers only while idle.
module es_descriptor_finder_unit
	import esdf_pkg::*;
#(
	parameter int unsigned LENGTH_BYTES = LengthBytesDefault
) (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire  [0:0]  s_axis_tuser,  // [0] first_byte

	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [7:0] payload_byte, [35:8] descriptor_length, zero
	output logic        m_axis_tlast,  // payload_last
	output logic [2:0]  m_axis_tuser,  // [0] payload_valid, [1] search_done, [2] found

	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CntW = $clog2(LENGTH_BYTES + 1);

	// Configuration registers.
	logic [TagW-1:0] wanted_tag_q;
	logic [PosW-1:0] buffer_length_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_tag_q    <= WantedTagReset;
			buffer_length_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				RegWantedTag:    wanted_tag_q    <= pwdata[TagW-1:0];
				RegBufferLength: buffer_length_q <= pwdata[PosW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			RegWantedTag:    prdata = {24'd0, wanted_tag_q};
			RegBufferLength: prdata = {16'd0, buffer_length_q};
			default: ;
		endcase
	end

	// Input register and output register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       advance;

	logic            valid_s2;
	logic [7:0]      out_byte_s2;
	logic [LenW-1:0] out_len_s2;
	logic            out_pvalid_s2;
	logic            out_plast_s2;
	logic            out_done_s2;
	logic            out_found_s2;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser[0];
		end
	end

	// Parser state.
	phase_t          phase_q, phase_d;
	logic [TagW-1:0] tag_q, tag_d;
	logic [LenW-1:0] acc_q, acc_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [LenW-1:0] btc_q, btc_d;
	logic [PosW-1:0] pos_q, pos_d;

	logic [7:0]      r_byte;
	logic [LenW-1:0] r_len;
	logic            r_pvalid, r_plast, r_done, r_found;

	logic            close_hdr;
	logic [LenW-1:0] skip_len;
	logic [LenW:0]   end_pos;

	always_comb begin
		phase_d   = phase_q;
		tag_d     = tag_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		btc_d     = btc_q;
		pos_d     = pos_q;
		r_byte    = '0;
		r_len     = '0;
		r_pvalid  = 1'b0;
		r_plast   = 1'b0;
		r_done    = 1'b0;
		r_found   = 1'b0;
		close_hdr = 1'b0;
		skip_len  = '0;
		end_pos   = '0;

		if (first_s1) begin
			pos_d = '0;
			btc_d = '0;
			if (buffer_length_q == '0) begin
				r_done  = 1'b1;
				phase_d = PH_IDLE;
			end else begin
				phase_d = PH_TAG;
			end
		end

		// An empty buffer on a first byte ends the search before any parsing.
		if (!(first_s1 && buffer_length_q == '0)) begin
			unique case (phase_d)
				PH_TAG: begin
					tag_d = byte_s1;
					acc_d = '0;
					cnt_d = '0;
					if (pos_d != PosMax) pos_d = pos_d + 1'b1;
					if (pos_d >= buffer_length_q) close_hdr = 1'b1;
					else phase_d = PH_LEN;
				end
				PH_LEN: begin
					acc_d = {acc_d[LenW-8:0], byte_s1[6:0] & LenBitsMask};
					cnt_d = cnt_d + 1'b1;
					if (pos_d != PosMax) pos_d = pos_d + 1'b1;
					if (!(byte_s1[7] && cnt_d < CntW'(LENGTH_BYTES)
						&& pos_d < buffer_length_q)) begin
						close_hdr = 1'b1;
					end
				end
				PH_SKIP: begin
					if (pos_d != PosMax) pos_d = pos_d + 1'b1;
					if (btc_d != '0) btc_d = btc_d - 1'b1;
					if (btc_d == '0) begin
						if (pos_d >= buffer_length_q) begin
							r_done  = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_TAG;
						end
					end else if (pos_d >= buffer_length_q) begin
						r_done  = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				PH_PAYLOAD: begin
					if (pos_d != PosMax) pos_d = pos_d + 1'b1;
					r_byte   = byte_s1;
					r_pvalid = 1'b1;
					if (btc_d != '0) btc_d = btc_d - 1'b1;
					if (btc_d == '0) begin
						r_plast = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		// End of the header: the length is complete or the buffer ran out.
		if (close_hdr) begin
			end_pos = {{(LenW + 1 - PosW){1'b0}}, pos_d} + {1'b0, acc_d};
			if (tag_d == TagEsDescr) skip_len = SkipEsDescr;
			else if (tag_d == TagDecConfig) skip_len = SkipDecConfig;
			else skip_len = acc_d;
			if (end_pos > {{(LenW + 1 - PosW){1'b0}}, buffer_length_q}) begin
				r_done  = 1'b1;
				phase_d = PH_IDLE;
			end else if (tag_d == wanted_tag_q) begin
				r_done  = 1'b1;
				r_found = 1'b1;
				r_len   = acc_d;
				if (acc_d != '0) begin
					btc_d   = acc_d;
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_IDLE;
				end
			end else if (skip_len == '0) begin
				if (pos_d >= buffer_length_q) begin
					r_done  = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					phase_d = PH_TAG;
				end
			end else if (pos_d >= buffer_length_q) begin
				r_done  = 1'b1;
				phase_d = PH_IDLE;
			end else begin
				btc_d   = skip_len;
				phase_d = PH_SKIP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tag_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			btc_q   <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			btc_q   <= btc_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_s2   <= r_byte;
			out_len_s2    <= r_len;
			out_pvalid_s2 <= r_pvalid;
			out_plast_s2  <= r_plast;
			out_done_s2   <= r_done;
			out_found_s2  <= r_found;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, out_len_s2, out_byte_s2};
	assign m_axis_tlast  = out_plast_s2;
	assign m_axis_tuser  = {out_found_s2, out_done_s2, out_pvalid_s2};

endmodule

`default_nettype wire
